[rtl/aee_pkg.sv]
// Package of shared constants and types for the armature EMF estimator.
`timescale 1ns / 1ps
package aee_pkg;
	localparam int unsigned DISCRETE_SCALE = 1;
	localparam int unsigned SPEED_SHIFT = 0;
	localparam logic [15:0] MAG_CLAMP = 16'(32'h01ff * DISCRETE_SCALE);

	typedef enum logic [2:0] {
		REG_UD_COMP_GAIN = 3'd0,
		REG_RESISTIVE_GAIN = 3'd1,
		REG_ERROR_GAIN = 3'd2,
		REG_INDUCTIVE_GAIN = 3'd3,
		REG_FILTER_THRESHOLD = 3'd4,
		REG_FILTER_MAX_DIVISOR = 3'd5,
		REG_FILTER_ENABLE = 3'd6,
		REG_INDEX_GAIN = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] armature_current;
		logic [14:0] prev_current;
		logic [14:0] boundary_current;
		logic signed [15:0] ud_average;
		logic bridge_two;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] emf_signed;
		logic [15:0] emf_magnitude;
		logic signed [15:0] emf_unfiltered;
		logic inverter_mode;
		logic [7:0] emf_table_index;
		logic [15:0] ud_comp_amount;
		logic signed [15:0] ud_compensated;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [15:0] data;
	} cfg_item_t;

	// Request and answer between the sequencer and the divider.
	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] quotient;
		logic [15:0] remainder;
	} div_rsp_t;
endpackage

[rtl/aee_stream_if.sv]
// Valid/ready channel interfaces for items and configuration writes.
`timescale 1ns / 1ps
interface aee_in_if;
	logic valid;
	logic ready;
	aee_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface aee_out_if;
	logic valid;
	logic ready;
	aee_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface aee_cfg_if;
	logic valid;
	logic ready;
	aee_pkg::cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/aee_divider.sv]
// Shared restoring divider, unsigned 32 by 16 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module aee_divider (
	input logic clk,
	input logic arst_n,
	input aee_pkg::div_req_t req,
	output aee_pkg::div_rsp_t rsp
);
	import aee_pkg::*;

	logic [5:0] count_q;
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [16:0] trial;
	logic busy_q, done_q;

	assign trial = {rem_q[15:0], quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				count_q <= 6'd32;
			end else if (busy_q) begin
				count_q <= count_q - 6'd1;
				if (count_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q[15:0];

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) rsp.done |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without a busy cycle");

	property p_start_loads;
		@(posedge clk) disable iff (!arst_n) (req.start && !busy_q) |=> busy_q;
	endproperty
	a_start_loads: assert property (p_start_loads)
		else $error("divider did not start");

	property p_not_done_busy;
		@(posedge clk) disable iff (!arst_n) !(rsp.done && busy_q);
	endproperty
	a_not_done_busy: assert property (p_not_done_busy)
		else $error("divider done while busy");
endmodule

[rtl/armature_emf_estimator.sv]
// Top level of the armature back-EMF estimator: sequencer, datapath and registers.
`timescale 1ns / 1ps
// An accepted item runs through the sequencer steps COMP, CWAIT (voltage
// compensation share in the shared divider), TERMS, ACCUM, COMB, FWAIT (filter
// quotient in the divider, only when the adaptive filter steps), FIN and OUT,
// and is then offered as a result.
// Throughput: one item at a time; in is ready again the cycle after the result
// transfer, so the next item is taken only after that transfer. Reset (arst_n
// low, asynchronous) clears the sequencer, configuration and estimator state,
// not the datapath registers; the filter divisor and its cap reset to one.
module armature_emf_estimator (
	input logic clk,
	input logic arst_n,
	aee_in_if.sink in,
	aee_out_if.source out,
	aee_cfg_if.sink cfg
);
	import aee_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_COMP = 9'b000000010,
		ST_CWAIT = 9'b000000100,
		ST_TERMS = 9'b000001000,
		ST_ACCUM = 9'b000010000,
		ST_COMB = 9'b000100000,
		ST_FWAIT = 9'b001000000,
		ST_FIN = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers. The error term is zero in every case, so its
	// gain has no effect and is not stored.
	logic [15:0] ud_comp_gain_q, resistive_gain_q, inductive_gain_q;
	logic [14:0] filter_threshold_q, filter_max_divisor_q;
	logic filter_enable_q;
	logic [15:0] index_gain_q;

	// Estimator state.
	logic [15:0] inductive_accum_q;
	logic inductive_sign_q;
	logic [15:0] filter_divisor_q;
	logic exceed_flag_q;
	logic [14:0] last_emf_magnitude_q;
	logic last_emf_sign_q;

	// Item working registers.
	in_item_t item_q;
	logic [15:0] comp_q, udc_q, mag_q, b_q, a_q, prevv_q, unf_q;
	logic s_ud_q, s_r_q, s_i_q, s_o_q;
	logic sd_neg_q;
	logic [15:0] div_q;
	out_item_t res_q;
	logic out_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	aee_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;
	assign out.valid = out_valid_q;
	assign out.data = res_q;

	// Combinational helpers, each the work of one sequencer step.
	logic cur_ge_bnd, prev_ge_bnd, cur_ge_prev;
	logic [15:0] cur16, prev16, bnd16, share;
	logic [31:0] comp_prod;
	assign cur16 = {1'b0, item_q.armature_current};
	assign prev16 = {1'b0, item_q.prev_current};
	assign bnd16 = {1'b0, item_q.boundary_current};
	assign cur_ge_bnd = cur16 >= bnd16;
	assign prev_ge_bnd = prev16 >= bnd16;
	assign cur_ge_prev = cur16 >= prev16;
	assign share = cur_ge_bnd ? bnd16 + 16'd1 : cur16;
	assign comp_prod = share * ud_comp_gain_q;

	// Compensation result once the divider finishes.
	logic [32:0] q33;
	logic [15:0] comp_n, udc_n, negu, mag_n;
	logic s_ud_n;
	assign q33 = {1'b0, drsp.quotient} + 33'd1;
	assign comp_n = (q33 > 33'h0ffff) ? 16'hffff : q33[15:0];
	assign udc_n = item_q.bridge_two ? item_q.ud_average - comp_n
		: item_q.ud_average + comp_n;
	assign negu = 16'd0 - udc_n;
	always_comb begin
		s_ud_n = udc_n[15];
		mag_n = udc_n[15] ? negu : udc_n;
		if (mag_n > MAG_CLAMP) mag_n = MAG_CLAMP;
		if (mag_n == 16'd0) s_ud_n = 1'b0;
	end

	// Current terms: change a, resistive b, sign flags.
	logic [15:0] a_n, b_n;
	logic s_i_n, s_r_n;
	logic [31:0] res_prod;
	assign res_prod = (cur16 - bnd16) * resistive_gain_q;
	always_comb begin
		a_n = '0;
		b_n = '0;
		s_i_n = 1'b0;
		s_r_n = 1'b0;
		if (cur_ge_bnd) begin
			if (prev_ge_bnd) begin
				if (cur_ge_prev) a_n = cur16 - prev16;
				else begin
					s_i_n = 1'b1;
					a_n = prev16 - cur16;
				end
			end else a_n = cur16 - bnd16 + 16'd1;
			s_r_n = 1'b1;
			b_n = res_prod[23:8];
		end else if (prev_ge_bnd) begin
			a_n = prev16 - bnd16 + 16'd1;
			s_i_n = 1'b1;
		end
	end

	// Inductive accumulator: decay by a sixth, then add or subtract the change.
	// x/6 for 16-bit x: (x * 43691) >> 18 is exact over the whole range.
	logic [31:0] sixth_prod, ind_prod;
	logic [15:0] decayed, d_n, acc_n;
	logic sign_n;
	assign sixth_prod = inductive_accum_q * 16'd43691;
	assign decayed = inductive_accum_q - {2'b0, sixth_prod[31:18]};
	assign ind_prod = a_q * inductive_gain_q;
	assign d_n = ind_prod[15:0];
	always_comb begin
		sign_n = inductive_sign_q;
		if (inductive_sign_q == s_i_q) acc_n = decayed + d_n;
		else if (decayed >= d_n) acc_n = decayed - d_n;
		else begin
			acc_n = d_n - decayed;
			sign_n = ~inductive_sign_q;
		end
	end

	// Combine error, inductive, resistive and voltage terms. The error term
	// is always zero, so c starts from the inductive share alone.
	logic [15:0] dd, cc, bb, bo, nowv, prevv_n, diffv;
	logic sr, so;
	always_comb begin
		dd = {8'd0, inductive_accum_q[15:8]};
		sr = s_r_q;
		if (inductive_sign_q == sr) cc = dd;
		else if (dd == 16'd0) cc = 16'd0;
		else begin
			cc = dd;
			sr = ~sr;
		end
		if (sr) begin
			if (b_q >= cc) begin
				bb = b_q - cc;
				sr = ~sr;
			end else bb = cc - b_q;
		end else bb = b_q + cc;
		if ((s_ud_q == sr) == item_q.bridge_two) begin
			bo = bb + mag_q;
			so = s_ud_q;
		end else if (bb >= mag_q) begin
			bo = bb - mag_q;
			so = ~s_ud_q;
		end else begin
			bo = mag_q - bb;
			so = s_ud_q;
		end
		if (bo == 16'd0) so = 1'b0;
		nowv = so ? 16'd0 - bo : bo;
		prevv_n = last_emf_sign_q ? 16'd0 - {1'b0, last_emf_magnitude_q}
			: {1'b0, last_emf_magnitude_q};
		diffv = nowv - prevv_n;
	end

	logic [15:0] unf_n, absdiff, div_n;
	logic exceed_n, big, filt_go;
	assign unf_n = 16'((so ? 16'd0 - {1'b0, bo[14:0]} : {1'b0, bo[14:0]}) << SPEED_SHIFT);
	assign absdiff = diffv[15] ? 16'd0 - diffv : diffv;
	assign big = absdiff >= {1'b0, filter_threshold_q};
	assign filt_go = filter_enable_q &&
		!(so == last_emf_sign_q && bo == {1'b0, last_emf_magnitude_q});
	always_comb begin
		div_n = filter_divisor_q;
		exceed_n = exceed_flag_q;
		if (big) begin
			if (exceed_flag_q) begin
				div_n = {1'b0, filter_divisor_q[15:1]};
				if (div_n == 16'd0) div_n = 16'd1;
			end else exceed_n = 1'b1;
		end else if (exceed_flag_q) exceed_n = 1'b0;
		else begin
			div_n = {filter_divisor_q[14:0], 1'b0};
			if (div_n > {1'b0, filter_max_divisor_q}) div_n = {1'b0, filter_max_divisor_q};
		end
		if (div_n == 16'd0) div_n = 16'd1;
	end
	// Signed divisor: a value with the top bit set is negative.
	logic [15:0] abs_div;
	assign abs_div = div_n[15] ? 16'd0 - div_n : div_n;

	// Filter step result: truncating signed quotient, at least one in magnitude
	// unless the difference itself is zero.
	logic [15:0] q16, quo_s, bf, bfm, fin, smag;
	logic qneg, sof;
	logic [31:0] idx_prod;
	assign qneg = sd_neg_q ^ div_q[15];
	always_comb begin
		q16 = drsp.quotient[15:0];
		if (q16 == 16'd0 && drsp.remainder != 16'd0) q16 = 16'd1;
		quo_s = qneg ? 16'd0 - q16 : q16;
		bf = prevv_q + quo_s;
		sof = bf[15];
		bfm = bf[15] ? 16'd0 - bf : bf;
	end

	always_comb begin
		fin = s_o_q ? 16'd0 - {1'b0, b_q[14:0]} : {1'b0, b_q[14:0]};
		smag = fin[15] ? 16'd0 - fin : fin;
	end
	assign idx_prod = smag * index_gain_q;

	always_comb begin
		dreq = '0;
		if (state_q == ST_COMP) begin
			dreq.start = 1'b1;
			dreq.dividend = comp_prod;
			dreq.divisor = bnd16 + 16'd1;
		end else if (state_q == ST_COMB && filt_go) begin
			dreq.start = 1'b1;
			dreq.dividend = {16'd0, absdiff};
			dreq.divisor = abs_div;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			ud_comp_gain_q <= '0;
			resistive_gain_q <= '0;
			inductive_gain_q <= '0;
			filter_threshold_q <= '0;
			filter_max_divisor_q <= 15'd1;
			filter_enable_q <= 1'b0;
			index_gain_q <= '0;
			inductive_accum_q <= '0;
			inductive_sign_q <= 1'b0;
			filter_divisor_q <= 16'd1;
			exceed_flag_q <= 1'b0;
			last_emf_magnitude_q <= '0;
			last_emf_sign_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (reg_idx_t'(cfg.data.index))
					REG_UD_COMP_GAIN: ud_comp_gain_q <= cfg.data.data;
					REG_RESISTIVE_GAIN: resistive_gain_q <= cfg.data.data;
					REG_ERROR_GAIN: ;
					REG_INDUCTIVE_GAIN: inductive_gain_q <= cfg.data.data;
					REG_FILTER_THRESHOLD: filter_threshold_q <= cfg.data.data[14:0];
					REG_FILTER_MAX_DIVISOR: filter_max_divisor_q <= cfg.data.data[14:0];
					REG_FILTER_ENABLE: filter_enable_q <= cfg.data.data[0];
					REG_INDEX_GAIN: index_gain_q <= cfg.data.data;
					default: ;
				endcase
			end
			if (out_valid_q && out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in.valid && in.ready) state_q <= ST_COMP;
				ST_COMP: state_q <= ST_CWAIT;
				ST_CWAIT: if (drsp.done) state_q <= ST_TERMS;
				ST_TERMS: state_q <= ST_ACCUM;
				ST_ACCUM: begin
					inductive_accum_q <= acc_n;
					inductive_sign_q <= sign_n;
					state_q <= ST_COMB;
				end
				ST_COMB: begin
					if (filt_go) begin
						filter_divisor_q <= div_n;
						exceed_flag_q <= exceed_n;
						state_q <= ST_FWAIT;
					end else begin
						last_emf_magnitude_q <= bo[14:0];
						last_emf_sign_q <= so;
						state_q <= ST_FIN;
					end
				end
				ST_FWAIT: if (drsp.done) begin
					last_emf_magnitude_q <= bfm[14:0];
					last_emf_sign_q <= sof;
					state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) item_q <= in.data;
		if (state_q == ST_CWAIT && drsp.done) begin
			comp_q <= comp_n;
			udc_q <= udc_n;
			mag_q <= mag_n;
			s_ud_q <= s_ud_n;
		end
		if (state_q == ST_TERMS) begin
			a_q <= a_n;
			b_q <= b_n;
			s_i_q <= s_i_n;
			s_r_q <= s_r_n;
		end
		if (state_q == ST_COMB) begin
			unf_q <= unf_n;
			b_q <= bo;
			s_o_q <= so;
			prevv_q <= prevv_n;
			sd_neg_q <= diffv[15];
			div_q <= div_n;
		end
		if (state_q == ST_FWAIT && drsp.done) begin
			b_q <= bfm;
			s_o_q <= sof;
		end
		if (state_q == ST_FIN) begin
			res_q.emf_signed <= 16'(fin << SPEED_SHIFT);
			res_q.emf_magnitude <= 16'(smag << SPEED_SHIFT);
			res_q.emf_unfiltered <= unf_q;
			res_q.inverter_mode <= fin[15] ? ~item_q.bridge_two : item_q.bridge_two;
			res_q.emf_table_index <= 8'((idx_prod / DISCRETE_SCALE) >> 8);
			res_q.ud_comp_amount <= comp_q;
			res_q.ud_compensated <= udc_q;
		end
	end

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in.ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy)
		else $error("input ready while an item is in work");

	property p_out_from_seq;
		@(posedge clk) disable iff (!arst_n) $rose(out_valid_q) |-> $past(state_q == ST_OUT);
	endproperty
	a_out_from_seq: assert property (p_out_from_seq)
		else $error("result raised outside the output step");

	property p_div_nonzero;
		@(posedge clk) disable iff (!arst_n) dreq.start |-> dreq.divisor != 16'd0;
	endproperty
	a_div_nonzero: assert property (p_div_nonzero)
		else $error("divide by zero requested");

	property p_fdiv_nonzero;
		@(posedge clk) disable iff (!arst_n) filter_divisor_q != 16'd0;
	endproperty
	a_fdiv_nonzero: assert property (p_fdiv_nonzero)
		else $error("filter divisor became zero");
endmodule

[bench/tb.sv]
// Self-checking testbench for the armature back-EMF estimator.
`timescale 1ns / 1ps
module tb;
	import aee_pkg::*;

	// Watchdog limit in cycles without any transfer. The longest quiet stretch
	// is the long receiver hold of LONG_HOLD plus the block's latency plus an
	// idle burst, so this is several times that.
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 120;

	logic clk;
	logic arst_n;

	aee_in_if in_ch();
	aee_out_if out_ch();
	aee_cfg_if cfg_ch();

	armature_emf_estimator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg(cfg_ch.sink)
	);

	// Local copy of the configuration registers, updated on every write transfer.
	logic [15:0] g_comp, g_res, g_err, g_ind, g_index;
	logic [14:0] f_thresh, f_maxdiv;
	logic f_en;

	// Local copy of the estimator state.
	logic [15:0] ind_acc, f_div;
	logic ind_sign, exceed, last_sign;
	logic [15:0] last_mag;

	in_item_t pend_q[$];
	out_item_t emf_q[$];

	int mismatches = 0;
	int items_in = 0;
	int results_out = 0;
	int filtered_steps = 0;
	bit quiet = 0;
	bit hold_go = 0;
	bit hold_taken = 0;
	int hold_cnt = 0;
	int in_gap = 0;
	int out_gap = 0;
	int stall = 0;

	// Works out one estimate and advances the local state, following the
	// sign/magnitude arithmetic of the block with 16-bit wrap everywhere.
	task automatic estimate_emf(input in_item_t x, output out_item_t r);
		logic [15:0] cur, prv, bnd, ud, share, comp, udc, mag;
		logic [15:0] a, b, c, d, unf, fin, smag, prevv, nowv, diff, dv;
		logic [31:0] q32, prod;
		logic two, s_ud, s_i, s_r, s_o;
		int sd, sv, quo, rem;
		cur = {1'b0, x.armature_current};
		prv = {1'b0, x.prev_current};
		bnd = {1'b0, x.boundary_current};
		ud = x.ud_average;
		two = x.bridge_two;

		// Voltage compensation, saturated at full scale.
		share = (cur >= bnd) ? 16'(bnd + 16'd1) : cur;
		q32 = 32'd1 + (32'(share) * 32'(g_comp)) / (32'(bnd) + 32'd1);
		comp = (q32 > 32'h0000_ffff) ? 16'hffff : q32[15:0];
		udc = two ? 16'(ud - comp) : 16'(ud + comp);

		s_ud = 1'b0;
		mag = udc;
		if (udc[15]) begin
			s_ud = 1'b1;
			mag = 16'(-udc);
		end
		if (mag > MAG_CLAMP)
			mag = MAG_CLAMP;
		if (mag == 16'd0)
			s_ud = 1'b0;

		// The inductive accumulator loses a sixth every step.
		ind_acc = 16'(ind_acc - ind_acc / 16'd6);

		s_i = 1'b0;
		s_r = 1'b0;
		a = '0;
		b = '0;
		c = '0;
		if (cur >= bnd) begin
			if (prv >= bnd) begin
				if (cur >= prv) begin
					a = 16'(cur - prv);
				end else begin
					s_i = 1'b1;
					a = 16'(prv - cur);
				end
			end else begin
				a = 16'(cur - bnd + 16'd1);
			end
			s_r = 1'b1;
			prod = 32'(16'(cur - bnd)) * 32'(g_res);
			b = prod[23:8];
		end else if (prv >= bnd) begin
			a = 16'(prv - bnd + 16'd1);
			s_i = 1'b1;
		end
		prod = 32'(c) * 32'(g_err);
		c = prod[23:8];

		d = 16'(32'(a) * 32'(g_ind));
		if (ind_sign == s_i) begin
			ind_acc = 16'(ind_acc + d);
		end else if (ind_acc >= d) begin
			ind_acc = 16'(ind_acc - d);
		end else begin
			ind_acc = 16'(d - ind_acc);
			ind_sign = ~ind_sign;
		end
		d = ind_acc >> 8;

		if (ind_sign == s_r) begin
			c = 16'(d + c);
		end else if (c >= d) begin
			c = 16'(c - d);
		end else begin
			c = 16'(d - c);
			s_r = ~s_r;
		end

		if (s_r) begin
			if (b >= c) begin
				b = 16'(b - c);
				s_r = ~s_r;
			end else begin
				b = 16'(c - b);
			end
		end else begin
			b = 16'(b + c);
		end

		// Combine the current terms with the compensated voltage.
		if ((s_ud == s_r) == two) begin
			b = 16'(b + mag);
			s_o = s_ud;
		end else if (b >= mag) begin
			b = 16'(b - mag);
			s_o = ~s_ud;
		end else begin
			b = 16'(mag - b);
			s_o = s_ud;
		end
		if (b == 16'd0)
			s_o = 1'b0;

		unf = {1'b0, b[14:0]};
		if (s_o)
			unf = 16'(-unf);
		unf = 16'(unf << SPEED_SHIFT);

		// Adaptive filter; a repeat of the last estimate leaves it untouched.
		if (f_en && !(s_o == last_sign && b == last_mag)) begin
			filtered_steps++;
			prevv = last_sign ? 16'(-last_mag) : last_mag;
			nowv = s_o ? 16'(-b) : b;
			diff = 16'(nowv - prevv);
			dv = f_div;
			sd = int'(signed'(diff));
			if (sd >= int'(f_thresh) || sd <= -int'(f_thresh)) begin
				if (exceed) begin
					dv = dv / 16'd2;
					if (dv < 16'd1)
						dv = 16'd1;
				end else begin
					exceed = 1'b1;
				end
			end else if (exceed) begin
				exceed = 1'b0;
			end else begin
				dv = 16'(dv * 16'd2);
				if (dv > {1'b0, f_maxdiv})
					dv = {1'b0, f_maxdiv};
			end
			if (dv == 16'd0)
				dv = 16'd1;
			sv = int'(signed'(dv));
			if (sv == 0)
				sv = 1;
			quo = sd / sv;
			rem = sd % sv;
			if (quo == 0 && rem > 0)
				quo = 1;
			if (quo == 0 && rem < 0)
				quo = -1;
			f_div = dv;
			b = 16'(prevv + 16'(quo));
			s_o = 1'b0;
			if (b[15]) begin
				b = 16'(-b);
				s_o = 1'b1;
			end
		end

		last_mag = {1'b0, b[14:0]};
		last_sign = s_o;

		fin = last_mag;
		if (s_o)
			fin = 16'(-fin);
		if (!fin[15]) begin
			smag = fin;
			r.inverter_mode = two;
		end else begin
			smag = 16'(-fin);
			r.inverter_mode = ~two;
		end
		prod = (32'(smag) * 32'(g_index)) / DISCRETE_SCALE;
		r.emf_table_index = prod[15:8];
		r.emf_signed = 16'(fin << SPEED_SHIFT);
		r.emf_magnitude = 16'(smag << SPEED_SHIFT);
		r.emf_unfiltered = unf;
		r.ud_comp_amount = comp;
		r.ud_compensated = udc;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Input driver: presents queued items, with random idle bursts until the
	// quiet part of the run. An offered item stays in place until it is taken.
	// The prediction is made at the accepting edge.
	always @(posedge clk) begin
		out_item_t r;
		logic nv;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				estimate_emf(pend_q.pop_front(), r);
				emf_q.push_back(r);
				items_in++;
			end
			nv = 1'b0;
			if (in_ch.valid && !in_ch.ready) begin
				nv = 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
			end else if (pend_q.size() > 0) begin
				nv = 1'b1;
				in_ch.data <= pend_q[0];
				if (!quiet && $urandom_range(0, 7) == 0)
					in_gap = $urandom_range(1, 16);
			end
			in_ch.valid <= nv;
		end
	end

	// Result receiver and checker, with random stalls and one long hold.
	always @(posedge clk) begin
		out_item_t e;
		out_item_t g;
		logic nr;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				g = out_ch.data;
				results_out++;
				if (emf_q.size() == 0) begin
					$error("result with no estimate pending");
					mismatches++;
				end else begin
					e = emf_q.pop_front();
					if (g.emf_signed !== e.emf_signed) begin
						$error("emf_signed exp %0d got %0d", e.emf_signed, g.emf_signed);
						mismatches++;
					end
					if (g.emf_magnitude !== e.emf_magnitude) begin
						$error("emf_magnitude exp %0d got %0d",
							e.emf_magnitude, g.emf_magnitude);
						mismatches++;
					end
					if (g.emf_unfiltered !== e.emf_unfiltered) begin
						$error("emf_unfiltered exp %0d got %0d",
							e.emf_unfiltered, g.emf_unfiltered);
						mismatches++;
					end
					if (g.inverter_mode !== e.inverter_mode) begin
						$error("inverter_mode exp %0b got %0b",
							e.inverter_mode, g.inverter_mode);
						mismatches++;
					end
					if (g.emf_table_index !== e.emf_table_index) begin
						$error("emf_table_index exp %0d got %0d",
							e.emf_table_index, g.emf_table_index);
						mismatches++;
					end
					if (g.ud_comp_amount !== e.ud_comp_amount) begin
						$error("ud_comp_amount exp %0d got %0d",
							e.ud_comp_amount, g.ud_comp_amount);
						mismatches++;
					end
					if (g.ud_compensated !== e.ud_compensated) begin
						$error("ud_compensated exp %0d got %0d",
							e.ud_compensated, g.ud_compensated);
						mismatches++;
					end
				end
			end
			nr = 1'b1;
			if (hold_go && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				nr = 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				nr = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 16);
			end
			out_ch.ready <= nr;
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, data: val};
		forever begin
			@(posedge clk);
			if (cfg_ch.ready)
				break;
		end
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_UD_COMP_GAIN: g_comp = val;
			REG_RESISTIVE_GAIN: g_res = val;
			REG_ERROR_GAIN: g_err = val;
			REG_INDUCTIVE_GAIN: g_ind = val;
			REG_FILTER_THRESHOLD: f_thresh = val[14:0];
			REG_FILTER_MAX_DIVISOR: f_maxdiv = val[14:0];
			REG_FILTER_ENABLE: f_en = val[0];
			REG_INDEX_GAIN: g_index = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [15:0] comp, res, err, ind,
			input logic [14:0] thr, maxd, input logic en, input logic [15:0] idxg);
		write_reg(REG_UD_COMP_GAIN, comp);
		write_reg(REG_RESISTIVE_GAIN, res);
		write_reg(REG_ERROR_GAIN, err);
		write_reg(REG_INDUCTIVE_GAIN, ind);
		write_reg(REG_FILTER_THRESHOLD, {1'b0, thr});
		write_reg(REG_FILTER_MAX_DIVISOR, {1'b0, maxd});
		write_reg(REG_FILTER_ENABLE, {15'd0, en});
		write_reg(REG_INDEX_GAIN, idxg);
	endtask

	function automatic in_item_t mk(input int cur, prv, bnd, ud, input bit two);
		in_item_t x;
		x.armature_current = 15'(cur);
		x.prev_current = 15'(prv);
		x.boundary_current = 15'(bnd);
		x.ud_average = 16'(ud);
		x.bridge_two = two;
		return x;
	endfunction

	// Mostly plausible operating points with currents around the boundary and
	// moderate voltages; the rest are raw values across the full field ranges.
	function automatic in_item_t rand_item();
		int bnd;
		int cur;
		int prv;
		if ($urandom_range(0, 9) < 7) begin
			bnd = $urandom_range(0, 3000);
			cur = bnd + $urandom_range(0, 600) - 300;
			prv = cur + $urandom_range(0, 200) - 100;
			if (cur < 0)
				cur = 0;
			if (prv < 0)
				prv = 0;
			return mk(cur, prv, bnd, $urandom_range(0, 1600) - 800,
				1'($urandom_range(0, 1)));
		end
		return mk($urandom_range(0, 32767), $urandom_range(0, 32767),
			$urandom_range(0, 32767), $urandom_range(0, 65535),
			1'($urandom_range(0, 1)));
	endfunction

	task automatic run_random(input int n);
		repeat (n)
			pend_q.push_back(rand_item());
		wait (pend_q.size() == 0 && emf_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		g_comp = '0;
		g_res = '0;
		g_err = '0;
		g_ind = '0;
		g_index = '0;
		f_thresh = '0;
		f_maxdiv = 15'd1;
		f_en = 1'b0;
		ind_acc = '0;
		ind_sign = 1'b0;
		f_div = 16'd1;
		exceed = 1'b0;
		last_sign = 1'b0;
		last_mag = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at reset settings, then with real gains and filtering.
		pend_q.push_back(mk(0, 0, 0, 0, 0));
		pend_q.push_back(mk(32767, 32767, 32767, 32767, 0));
		pend_q.push_back(mk(0, 0, 0, -32768, 1));
		wait (pend_q.size() == 0 && emf_q.size() == 0);
		repeat (SETTLE) @(posedge clk);

		set_all(16'hffff, 16'h0180, 16'h0100, 16'h0040, 15'd20, 15'd8, 1'b1, 16'h0200);
		// Current above boundary, rising then falling.
		pend_q.push_back(mk(500, 400, 300, 200, 0));
		pend_q.push_back(mk(400, 500, 300, 200, 0));
		// Crossing into and out of the continuous region.
		pend_q.push_back(mk(500, 100, 300, -200, 1));
		pend_q.push_back(mk(100, 500, 300, -200, 1));
		pend_q.push_back(mk(100, 100, 300, 0, 0));
		// Magnitude clamp on both polarities.
		pend_q.push_back(mk(10, 10, 10, 30000, 0));
		pend_q.push_back(mk(10, 10, 10, -30000, 1));
		// Compensation saturating: tiny boundary, big current, full gain.
		pend_q.push_back(mk(32767, 0, 0, 0, 0));
		// Repeat the same point so the filter sees an unchanged estimate.
		pend_q.push_back(mk(100, 100, 300, 0, 0));
		pend_q.push_back(mk(100, 100, 300, 0, 0));
		// Voltage that cancels the compensation exactly to zero.
		pend_q.push_back(mk(0, 0, 100, -1, 0));
		pend_q.push_back(mk(0, 0, 100, 1, 1));
		pend_q.push_back(mk(32767, 32767, 0, -32768, 1));
		pend_q.push_back(mk(0, 32767, 32767, 32767, 1));
		run_random(30);

		// Long receiver hold while the sender keeps offering.
		set_all(16'h0100, 16'h0040, 16'h0080, 16'h1000, 15'd0, 15'd32767, 1'b1, 16'hffff);
		hold_go = 1'b1;
		run_random(100);

		// Extremes: everything at full scale, then minimum settings.
		set_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 15'd32767, 15'd32767, 1'b1,
			16'hffff);
		run_random(80);
		set_all(16'h0000, 16'h0000, 16'h0000, 16'h0001, 15'd0, 15'd1, 1'b1, 16'h0001);
		run_random(60);

		// Random settings, filter off for the unfiltered path.
		set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			15'($urandom_range(0, 400)), 15'($urandom_range(1, 64)), 1'b0,
			16'($urandom));
		run_random(80);

		// Final stretch with no idling on either side.
		quiet = 1'b1;
		set_all(16'($urandom), 16'($urandom_range(0, 1023)), 16'($urandom),
			16'($urandom_range(0, 4095)), 15'($urandom_range(0, 200)),
			15'($urandom_range(1, 32)), 1'b1, 16'($urandom));
		run_random(80);

		$display("%0d items in, %0d results checked, %0d filter updates",
			items_in, results_out, filtered_steps);
		$display("covered reset, directed, full-scale, minimum and random settings");
		if (mismatches == 0 && emf_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

[files.f]
rtl/aee_pkg.sv
rtl/aee_stream_if.sv
rtl/aee_divider.sv
rtl/armature_emf_estimator.sv
bench/tb.sv
